@@ hw/rtl/bpa_pkg.sv @@
// Shared types and constants for the buddy page allocator.
// Depends on nothing; every other file of the block but bpa_ram imports it.
package bpa_pkg;

    localparam int BPA_TOTAL_PAGES = 32768;
    localparam int REQ_W           = 16;
    localparam int PAGE_W          = 15;
    localparam int LOG_W           = 5;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_START,
        ST_CHECK,
        ST_DOWN_RD,
        ST_DOWN_DEC,
        ST_FREE_RD,
        ST_FREE_DEC,
        ST_UP_RD,
        ST_UP_WR,
        ST_FINISH
    } t_state;

    typedef enum logic [3:0] {
        OP_NOP,
        OP_CLR,
        OP_LOAD,
        OP_RD_ROOT,
        OP_SET_FAIL,
        OP_DOWN_INIT,
        OP_DOWN_RD,
        OP_DOWN_DEC,
        OP_MARK,
        OP_FREE_INIT,
        OP_FREE_RD,
        OP_FREE_MARK,
        OP_FREE_UP,
        OP_UP_RD,
        OP_UP_WR,
        OP_OUT
    } t_dp_op;

    typedef struct packed {
        logic clr_done;
        logic is_free;
        logic page_bad;
        logic bad_req;
        logic at_want;
        logic at_root;
        logic node_zero;
        logic parent_root;
        logic out_free;
    } t_dp_sts;

endpackage

@@ hw/rtl/bpa_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Depends on nothing.
module bpa_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ hw/rtl/bpa_dp.sv @@
// Datapath of the buddy page allocator: node tree memory, walk registers,
// clearing counter and result register. Depends on bpa_pkg and bpa_ram.
module bpa_dp #(
    parameter int TOTAL_PAGES = bpa_pkg::BPA_TOTAL_PAGES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  bpa_pkg::t_dp_op             i_op,
    output bpa_pkg::t_dp_sts            o_sts,
    input  logic                        i_mode,
    input  logic [bpa_pkg::REQ_W-1:0]   i_request_pages,
    input  logic [bpa_pkg::PAGE_W-1:0]  i_free_page,
    input  logic                        i_out_stall,
    output logic                        o_out_valid,
    output logic [bpa_pkg::PAGE_W-1:0]  o_page_number,
    output logic                        o_failed
);
    import bpa_pkg::*;

    localparam int LOG_N      = $clog2(TOTAL_PAGES);
    localparam int BUDDY_N    = 1 << LOG_N;
    localparam int NODE_COUNT = 2 * BUDDY_N - 1;
    localparam int NODE_W     = LOG_N + 1;
    localparam int VAL_W      = LOG_N + 1;
    localparam int XW         = ((NODE_W > PAGE_W) ? NODE_W : PAGE_W) + 1;
    localparam int PW         = (LOG_N > PAGE_W) ? LOG_N : PAGE_W;

    // item registers
    logic                r_is_free;
    logic [REQ_W-1:0]    r_req;
    logic [PAGE_W-1:0]   r_free_page;
    logic                r_fail;
    logic [VAL_W-1:0]    r_want;
    logic                r_want_big;

    // walk registers
    logic [NODE_W-1:0]   r_idx;
    logic [VAL_W-1:0]    r_size;
    logic [VAL_W-1:0]    r_cur;
    logic [LOG_N-1:0]    r_page;

    // clearing pass
    logic [NODE_W-1:0]   r_clr_idx;
    logic [VAL_W-1:0]    r_clr_val;

    // result register
    logic                r_out_valid;
    logic [PAGE_W-1:0]   r_out_page;
    logic                r_out_failed;

    // memory ports
    logic                ram_we;
    logic [NODE_W-1:0]   ram_waddr;
    logic [VAL_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [NODE_W-1:0]   ram_raddr;
    logic [VAL_W-1:0]    ram_rdata;

    // derived values
    logic [LOG_W-1:0]    want_log;
    logic [REQ_W-1:0]    req_m1;
    logic [NODE_W-1:0]   idx_m1;
    logic [NODE_W-1:0]   parent;
    logic [NODE_W-1:0]   sibling;
    logic [NODE_W-1:0]   left_child;
    logic [NODE_W-1:0]   leaf_idx;
    logic                page_bad;
    logic [VAL_W-1:0]    left_val;
    logic [VAL_W-1:0]    right_val;
    logic [VAL_W:0]      pair_sum;
    logic [VAL_W-1:0]    parent_size;
    logic [VAL_W-1:0]    pair_max;
    logic [VAL_W-1:0]    parent_val;
    logic [NODE_W-1:0]   clr_next;
    logic [NODE_W-1:0]   clr_next_p1;
    logic [PW-1:0]       page_wide;

    bpa_ram #(
        .WIDTH (VAL_W),
        .DEPTH (NODE_COUNT)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_we),
        .i_wr_addr (ram_waddr),
        .i_wr_data (ram_wdata),
        .i_rd_en   (ram_re),
        .i_rd_addr (ram_raddr),
        .o_rd_data (ram_rdata)
    );

    // ceil(log2(request)), zero counting as one
    always_comb begin
        req_m1   = r_req - REQ_W'(1);
        want_log = '0;
        if (r_req > REQ_W'(1)) begin
            for (int i = 0; i < REQ_W; i++) begin
                if (req_m1[i]) begin
                    want_log = LOG_W'(i + 1);
                end
            end
        end
    end

    assign idx_m1     = r_idx - NODE_W'(1);
    assign parent     = {1'b0, idx_m1[NODE_W-1:1]};
    assign sibling    = r_idx[0] ? (r_idx + NODE_W'(1)) : idx_m1;
    assign left_child = {r_idx[NODE_W-2:0], 1'b1};
    assign page_bad   = XW'(r_free_page) >= XW'(BUDDY_N);
    assign leaf_idx   = NODE_W'(XW'(r_free_page) + XW'(BUDDY_N - 1));

    // an odd index is a left child
    assign left_val    = r_idx[0] ? r_cur : ram_rdata;
    assign right_val   = r_idx[0] ? ram_rdata : r_cur;
    assign pair_sum    = {1'b0, left_val} + {1'b0, right_val};
    assign parent_size = r_size << 1;
    assign pair_max    = (left_val > right_val) ? left_val : right_val;
    assign parent_val  = (r_is_free && (pair_sum == {1'b0, parent_size})) ?
                         parent_size : pair_max;

    assign clr_next    = r_clr_idx + NODE_W'(1);
    assign clr_next_p1 = clr_next + NODE_W'(1);
    assign page_wide   = PW'(r_page);

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = r_idx;
        case (i_op)
            OP_CLR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = r_clr_val;
            end
            OP_RD_ROOT: begin
                ram_re    = 1'b1;
                ram_raddr = '0;
            end
            OP_DOWN_RD: begin
                ram_re    = 1'b1;
                ram_raddr = left_child;
            end
            OP_MARK: begin
                ram_we    = 1'b1;
            end
            OP_FREE_RD: begin
                ram_re    = 1'b1;
            end
            OP_FREE_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = r_size;
            end
            OP_UP_RD: begin
                ram_re    = 1'b1;
                ram_raddr = sibling;
            end
            OP_UP_WR: begin
                ram_we    = 1'b1;
                ram_waddr = parent;
                ram_wdata = parent_val;
            end
            default: begin
                ram_we    = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx   <= '0;
            r_clr_val   <= VAL_W'(BUDDY_N);
            r_out_valid <= 1'b0;
        end else begin
            if (i_op == OP_CLR) begin
                r_clr_idx <= clr_next;
                // halve at the first node of each level
                if ((clr_next_p1 & clr_next) == '0) begin
                    r_clr_val <= r_clr_val >> 1;
                end
            end
            if (i_op == OP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_LOAD: begin
                r_is_free   <= i_mode;
                r_req       <= i_request_pages;
                r_free_page <= i_free_page;
                r_fail      <= 1'b0;
            end
            OP_RD_ROOT: begin
                r_want     <= VAL_W'(1) << want_log;
                r_want_big <= want_log > LOG_W'(LOG_N);
            end
            OP_SET_FAIL: begin
                r_fail <= 1'b1;
            end
            OP_DOWN_INIT: begin
                r_idx  <= '0;
                r_size <= VAL_W'(BUDDY_N);
                r_page <= '0;
            end
            OP_DOWN_DEC: begin
                r_size <= r_size >> 1;
                if (ram_rdata >= r_want) begin
                    r_idx <= left_child;
                end else begin
                    r_idx  <= left_child + NODE_W'(1);
                    r_page <= r_page + LOG_N'(r_size >> 1);
                end
            end
            OP_MARK: begin
                r_cur <= '0;
            end
            OP_FREE_INIT: begin
                r_idx  <= leaf_idx;
                r_size <= VAL_W'(1);
            end
            OP_FREE_MARK: begin
                r_cur <= r_size;
            end
            OP_FREE_UP: begin
                r_idx  <= parent;
                r_size <= parent_size;
            end
            OP_UP_WR: begin
                r_idx  <= parent;
                r_size <= parent_size;
                r_cur  <= parent_val;
            end
            OP_OUT: begin
                r_out_failed <= r_fail;
                r_out_page   <= (r_fail || r_is_free) ? '0 : page_wide[PAGE_W-1:0];
            end
            default: begin
                r_fail <= r_fail;
            end
        endcase
    end

    always_comb begin
        o_sts.clr_done    = r_clr_idx == NODE_W'(NODE_COUNT - 1);
        o_sts.is_free     = r_is_free;
        o_sts.page_bad    = page_bad;
        o_sts.bad_req     = r_want_big || (ram_rdata < r_want);
        o_sts.at_want     = r_size == r_want;
        o_sts.at_root     = r_idx == '0;
        o_sts.node_zero   = ram_rdata == '0;
        o_sts.parent_root = parent == '0;
        o_sts.out_free    = !r_out_valid || !i_out_stall;
    end

    assign o_out_valid   = r_out_valid;
    assign o_page_number = r_out_page;
    assign o_failed      = r_out_failed;

endmodule

@@ hw/rtl/bpa_ctrl.sv @@
// Controller of the buddy page allocator: sequences the clearing pass and
// each allocate or free walk. Depends on bpa_pkg.
module bpa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  bpa_pkg::t_dp_sts  i_sts,
    output bpa_pkg::t_dp_op   o_op
);
    import bpa_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_sts.clr_done) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_START;
            end
            ST_START: begin
                if (!i_sts.is_free) n_state = ST_CHECK;
                else if (i_sts.page_bad) n_state = ST_FINISH;
                else n_state = ST_FREE_RD;
            end
            ST_CHECK: begin
                n_state = i_sts.bad_req ? ST_FINISH : ST_DOWN_RD;
            end
            ST_DOWN_RD: begin
                if (!i_sts.at_want) n_state = ST_DOWN_DEC;
                else if (i_sts.at_root) n_state = ST_FINISH;
                else n_state = ST_UP_RD;
            end
            ST_DOWN_DEC: begin
                n_state = ST_DOWN_RD;
            end
            ST_FREE_RD: begin
                n_state = ST_FREE_DEC;
            end
            ST_FREE_DEC: begin
                if (i_sts.node_zero) begin
                    n_state = i_sts.at_root ? ST_FINISH : ST_UP_RD;
                end else begin
                    n_state = i_sts.at_root ? ST_FINISH : ST_FREE_RD;
                end
            end
            ST_UP_RD: begin
                n_state = ST_UP_WR;
            end
            ST_UP_WR: begin
                n_state = i_sts.parent_root ? ST_FINISH : ST_UP_RD;
            end
            ST_FINISH: begin
                if (i_sts.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_op       = OP_NOP;
        o_in_stall = (r_state != ST_IDLE);
        case (r_state)
            ST_CLEAR: begin
                o_op = OP_CLR;
            end
            ST_IDLE: begin
                if (i_in_valid) o_op = OP_LOAD;
            end
            ST_START: begin
                if (!i_sts.is_free) o_op = OP_RD_ROOT;
                else if (i_sts.page_bad) o_op = OP_SET_FAIL;
                else o_op = OP_FREE_INIT;
            end
            ST_CHECK: begin
                o_op = i_sts.bad_req ? OP_SET_FAIL : OP_DOWN_INIT;
            end
            ST_DOWN_RD: begin
                o_op = i_sts.at_want ? OP_MARK : OP_DOWN_RD;
            end
            ST_DOWN_DEC: begin
                o_op = OP_DOWN_DEC;
            end
            ST_FREE_RD: begin
                o_op = OP_FREE_RD;
            end
            ST_FREE_DEC: begin
                if (i_sts.node_zero) o_op = OP_FREE_MARK;
                else if (i_sts.at_root) o_op = OP_SET_FAIL;
                else o_op = OP_FREE_UP;
            end
            ST_UP_RD: begin
                o_op = OP_UP_RD;
            end
            ST_UP_WR: begin
                o_op = OP_UP_WR;
            end
            ST_FINISH: begin
                if (i_sts.out_free) o_op = OP_OUT;
            end
            default: begin
                o_op = OP_NOP;
            end
        endcase
    end

endmodule

@@ hw/rtl/buddy_page_allocator_top.sv @@
// Buddy page allocator, top level. N is TOTAL_PAGES rounded up to a power of
// two; a free of a page at or beyond N fails. Each tree level on each pass
// needs a read of the node memory, which has a single read port. One word at
// a time: a new word is taken only after the result of the last one has been
// registered; a stalled result holds the walk at its end.
// Reset: synchronous, active low, then a clearing pass over all 2N-1 nodes.
module buddy_page_allocator_top #(
    parameter int TOTAL_PAGES = bpa_pkg::BPA_TOTAL_PAGES
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    // input channel
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic                        i_mode,
    input  logic [bpa_pkg::REQ_W-1:0]   i_request_pages,
    input  logic [bpa_pkg::PAGE_W-1:0]  i_free_page,
    // result channel
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [bpa_pkg::PAGE_W-1:0]  o_page_number,
    output logic                        o_failed
);
    import bpa_pkg::*;

    // Command from the controller to the datapath, one per cycle.
    t_dp_op  op;
    // Flags from the datapath that steer the walk.
    t_dp_sts sts;

    // The controller owns the handshake on the input side: stall is low only
    // in the idle state, so a word is taken exactly when the walk may begin.
    bpa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_op       (op)
    );

    // The datapath holds the node tree (one node per memory word, each the
    // largest free power-of-two run below it), the walk registers and the
    // result register, which parts the result side from the walk so that a
    // new word can start while the last result is still held.
    bpa_dp #(
        .TOTAL_PAGES (TOTAL_PAGES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_op            (op),
        .o_sts           (sts),
        .i_mode          (i_mode),
        .i_request_pages (i_request_pages),
        .i_free_page     (i_free_page),
        .i_out_stall     (i_out_stall),
        .o_out_valid     (o_out_valid),
        .o_page_number   (o_page_number),
        .o_failed        (o_failed)
    );

endmodule

@@ hw/rtl/bpa_checker.sv @@
// Port-level checker for the buddy page allocator, bound to the top level.
// Depends on bpa_pkg for field widths.
module bpa_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_mode,
    input logic [bpa_pkg::REQ_W-1:0]   i_request_pages,
    input logic [bpa_pkg::PAGE_W-1:0]  i_free_page,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [bpa_pkg::PAGE_W-1:0]  o_page_number,
    input logic                        o_failed
);
    import bpa_pkg::*;

    // hold a stalled result word
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_page_number) && $stable(o_failed)))
        else $error("stalled result word changed");

    // a failed word carries page zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_failed) |-> (o_page_number == '0))
        else $error("failed result with nonzero page");

    // one word at a time: stall rises right after a take
    a_one_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("second word taken while walking");

    // a new result only follows work in progress
    a_out_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared with no word at work");

endmodule

bind buddy_page_allocator_top bpa_checker u_bpa_checker (.*);
